// ===== rtl/tuk_pkg.sv =====
// Shared types, constants and the digit multiply function for the uptime keeper.
package tuk_pkg;

    // Nanoseconds in one second, and twice that, for normalization
    localparam logic [29:0] ONE_SEC_NS = 30'd1_000_000_000;
    localparam logic [30:0] TWO_SEC_NS = 31'd2_000_000_000;

    // Converted product width and iteration counter width of the divider
    localparam int PROD_W = 64;
    localparam int ITER_W = 6;

    // Item command carried in tuser
    typedef enum logic
    {
        CMD_TICK  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0]
    {
        REG_COUNTER_MASK = 2'd0,
        REG_COUNTER_FREQ = 2'd1,
        REG_BOOT_SEC     = 2'd2,
        REG_BOOT_NSEC    = 2'd3
    } cfg_reg_t;

    // Result of one count-to-nanosecond conversion
    typedef struct packed
    {
        logic [63:0] nsd;       // converted delta in nanoseconds
        logic [31:0] sec_inc;   // nsd / 1e9, low 32 bits
        logic [29:0] nsec_rem;  // nsd % 1e9
    } conv_result_t;

    // One hex digit times one billion (below 2^34)
    function automatic logic [33:0] ns_times_digit(input logic [3:0] d);
        logic [63:0] p;
        p = 64'(d) * 64'(ONE_SEC_NS);
        return p[33:0];
    endfunction

endpackage

// ===== rtl/timecounter_uptime_keeper.sv =====
// Uptime keeper: two alternating time hands updated from counter samples.
// Each item is converted by a hex-digit multiply by 1e9, then a 64-step
//   radix-2 divider by the frequency feeding the seconds split.
// A new item is taken only while idle, once the previous result is loaded.
// Reset: registers take their reset values, both hands clear, first hand current.
module timecounter_uptime_keeper #(
    parameter int COUNTER_WIDTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [63:0] counter_value
    input  logic         s_tuser,   // [0] cmd
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // [63:0] stored_ns, [95:64] stored_sec,
                                    // [125:96] stored_nsec, [189:126] now_ns,
                                    // [221:190] now_sec, [251:222] now_nsec,
                                    // [284:252] since_boot_sec,
                                    // [314:285] since_boot_nsec, rest zero
    // configuration writes
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int W = COUNTER_WIDTH;

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_CONV   = 4'b0010,
        S_SUM    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                 state_reg;
    tuk_pkg::cmd_t          cmd_reg;
    logic                   hsel_reg;
    logic                   cur_reg;
    logic [W-1:0]           sample_reg;

    logic [63:0]            mask_reg;
    logic [31:0]            freq_reg;
    logic [31:0]            boot_sec_reg;
    logic [29:0]            boot_nsec_reg;

    logic [W-1:0]           hand_count_reg [2];
    logic [63:0]            hand_ns_reg    [2];
    logic [31:0]            hand_sec_reg   [2];
    logic [29:0]            hand_nsec_reg  [2];

    logic [63:0]            now_ns_reg;
    logic [31:0]            now_sec_reg;
    logic [29:0]            now_nsec_reg;

    logic                   m_tvalid_reg;
    logic [319:0]           m_tdata_reg;

    // Input side
    tuk_pkg::cmd_t          cmd_in;
    logic                   hsel_in;
    logic [W-1:0]           sample_in;
    logic [W-1:0]           delta_in;
    logic                   in_xact;
    logic [31:0]            freq_eff;

    // Converter
    logic                   conv_done;
    tuk_pkg::conv_result_t  conv_res;

    // Sum stage
    logic [63:0]            ns_sum;
    logic [30:0]            nsec_sum;
    logic                   nsec_wrap;
    logic [29:0]            nsec_fix;
    logic [31:0]            sec_fix;

    // Finish stage
    logic [30:0]            boot_n;
    logic                   boot_ge1;
    logic                   boot_ge2;
    logic [1:0]             boot_q;
    logic [29:0]            since_nsec;
    logic [32:0]            since_sec;
    logic                   out_free;
    logic                   out_load;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xact   = s_tvalid && s_tready;
    assign cmd_in    = tuk_pkg::cmd_t'(s_tuser);
    assign hsel_in   = (cmd_in == tuk_pkg::CMD_TICK) ? ~cur_reg : cur_reg;
    assign sample_in = s_tdata[W-1:0];
    assign delta_in  = (sample_in - hand_count_reg[hsel_in]) & mask_reg[W-1:0];
    assign freq_eff  = (freq_reg == '0) ? 32'd1 : freq_reg;

    tuk_nsconv #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_nsconv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (in_xact),
        .delta   (delta_in),
        .divisor (freq_eff),
        .done    (conv_done),
        .result  (conv_res)
    );

    // Hand plus converted delta, nanoseconds normalized once
    assign ns_sum    = hand_ns_reg[hsel_reg] + conv_res.nsd;
    assign nsec_sum  = 31'(hand_nsec_reg[hsel_reg]) + 31'(conv_res.nsec_rem);
    assign nsec_wrap = nsec_sum >= 31'(tuk_pkg::ONE_SEC_NS);
    assign nsec_fix  = nsec_wrap ? 30'(nsec_sum - 31'(tuk_pkg::ONE_SEC_NS))
                                 : nsec_sum[29:0];
    assign sec_fix   = hand_sec_reg[hsel_reg] + conv_res.sec_inc + 32'(nsec_wrap);

    // Boot-relative time; boot_nsec may exceed one second, so up to two carries
    assign boot_n   = 31'(boot_nsec_reg) + 31'(hand_nsec_reg[cur_reg]);
    assign boot_ge1 = boot_n >= 31'(tuk_pkg::ONE_SEC_NS);
    assign boot_ge2 = boot_n >= tuk_pkg::TWO_SEC_NS;
    assign boot_q   = boot_ge2 ? 2'd2 : (boot_ge1 ? 2'd1 : 2'd0);
    assign since_nsec = boot_ge2 ? 30'(boot_n - tuk_pkg::TWO_SEC_NS)
                      : boot_ge1 ? 30'(boot_n - 31'(tuk_pkg::ONE_SEC_NS))
                      : boot_n[29:0];
    assign since_sec = 33'(boot_sec_reg) + 33'(hand_sec_reg[cur_reg]) + 33'(boot_q);

    // Output register handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_FINISH) && out_free;

    // Control, configuration and hand state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= tuk_pkg::CMD_TICK;
            hsel_reg      <= 1'b0;
            cur_reg       <= 1'b0;
            mask_reg      <= '1;
            freq_reg      <= 32'd1_000_000;
            boot_sec_reg  <= '0;
            boot_nsec_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                hand_count_reg[i] <= '0;
                hand_ns_reg[i]    <= '0;
                hand_sec_reg[i]   <= '0;
                hand_nsec_reg[i]  <= '0;
            end
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                unique case (tuk_pkg::cfg_reg_t'(cfg_index))
                    tuk_pkg::REG_COUNTER_MASK: mask_reg      <= cfg_data;
                    tuk_pkg::REG_COUNTER_FREQ: freq_reg      <= cfg_data[31:0];
                    tuk_pkg::REG_BOOT_SEC:     boot_sec_reg  <= cfg_data[31:0];
                    tuk_pkg::REG_BOOT_NSEC:    boot_nsec_reg <= cfg_data[29:0];
                    default:                   mask_reg      <= mask_reg;
                endcase
            end

            // result register
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xact)
                    begin
                        cmd_reg   <= cmd_in;
                        hsel_reg  <= hsel_in;
                        state_reg <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    if (conv_done)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    // a tick commits the other hand and makes it current
                    if (cmd_reg == tuk_pkg::CMD_TICK)
                    begin
                        hand_count_reg[hsel_reg] <= sample_reg;
                        hand_ns_reg[hsel_reg]    <= ns_sum;
                        hand_sec_reg[hsel_reg]   <= sec_fix;
                        hand_nsec_reg[hsel_reg]  <= nsec_fix;
                        cur_reg                  <= hsel_reg;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            sample_reg <= sample_in;
        end
        if (state_reg == S_SUM)
        begin
            now_ns_reg   <= ns_sum;
            now_sec_reg  <= sec_fix;
            now_nsec_reg <= nsec_fix;
        end
        if (out_load)
        begin
            m_tdata_reg <= {5'd0, since_nsec, since_sec,
                            now_nsec_reg, now_sec_reg, now_ns_reg,
                            hand_nsec_reg[cur_reg], hand_sec_reg[cur_reg],
                            hand_ns_reg[cur_reg]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Converter finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == S_CONV))
        else $error("converter done outside conversion wait");

    // Stored nanosecond parts stay normalized
    assert property (@(posedge clk) disable iff (!rst_n)
        (hand_nsec_reg[0] < tuk_pkg::ONE_SEC_NS) &&
        (hand_nsec_reg[1] < tuk_pkg::ONE_SEC_NS))
        else $error("hand nanoseconds out of range");

    // A tick always switches the current hand
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) && (cmd_reg == tuk_pkg::CMD_TICK)
        |=> (cur_reg != $past(cur_reg)))
        else $error("tick did not switch hands");

    // A finished result holds while the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) && m_tvalid_reg && !m_tready
        |=> (state_reg == S_FINISH))
        else $error("result dropped while output busy");

endmodule

// ===== rtl/tuk_nsconv.sv =====
// Digit-serial count-to-nanosecond converter: multiply, divide and split.
module tuk_nsconv #(
    parameter int COUNTER_WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [COUNTER_WIDTH-1:0]  delta,
    input  logic [31:0]               divisor,   // nonzero
    output logic                      done,
    output tuk_pkg::conv_result_t     result
);

    localparam int DIGITS = (COUNTER_WIDTH + 3) / 4;
    localparam int DIG_W  = DIGITS * 4;
    localparam int DCNT_W = $clog2(DIGITS);

    typedef enum logic [3:0]
    {
        C_IDLE  = 4'b0001,
        C_MUL   = 4'b0010,
        C_DIV   = 4'b0100,
        C_DRAIN = 4'b1000
    } cstate_t;

    cstate_t                         state_reg, state_next;
    logic [DCNT_W-1:0]               dcnt_reg, dcnt_next;
    logic [tuk_pkg::ITER_W-1:0]      icnt_reg, icnt_next;
    logic                            qvld_reg, qvld_next;
    logic                            done_reg, done_next;
    logic [DIG_W-1:0]                digits_reg, digits_next;
    logic [tuk_pkg::PROD_W-1:0]      acc_reg, acc_next;
    logic [31:0]                     rem_reg, rem_next;
    logic                            qbit_reg, qbit_next;
    logic [29:0]                     srem_reg, srem_next;
    logic [31:0]                     sec_reg, sec_next;

    logic [32:0]                     trial;
    logic [32:0]                     trial_sub;
    logic                            trial_ge;
    logic [30:0]                     trial2;
    logic [30:0]                     trial2_sub;
    logic                            trial2_ge;

    // Restoring step against the frequency, one quotient bit per cycle
    assign trial     = {rem_reg, acc_reg[tuk_pkg::PROD_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    // Second restoring step against one billion, fed by last cycle's bit
    assign trial2     = {srem_reg, qbit_reg};
    assign trial2_ge  = trial2 >= 31'(tuk_pkg::ONE_SEC_NS);
    assign trial2_sub = trial2 - 31'(tuk_pkg::ONE_SEC_NS);

    always_comb
    begin
        state_next  = state_reg;
        dcnt_next   = dcnt_reg;
        icnt_next   = icnt_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        qbit_next   = qbit_reg;
        srem_next   = srem_reg;
        sec_next    = sec_reg;
        done_next   = 1'b0;
        qvld_next   = (state_reg == C_DIV);

        // seconds split takes each quotient bit in the cycle after the main divider makes it
        if (qvld_reg)
        begin
            srem_next = trial2_ge ? trial2_sub[29:0] : trial2[29:0];
            sec_next  = {sec_reg[30:0], trial2_ge};
        end

        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    digits_next = DIG_W'(delta);
                    acc_next    = '0;
                    dcnt_next   = '0;
                    state_next  = C_MUL;
                end
            end
            C_MUL:
            begin
                // Horner form, most significant hex digit first
                acc_next = (acc_reg << 4)
                         + 64'(tuk_pkg::ns_times_digit(digits_reg[DIG_W-1 -: 4]));
                digits_next = digits_reg << 4;
                dcnt_next   = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIGITS - 1))
                begin
                    rem_next   = '0;
                    icnt_next  = '0;
                    srem_next  = '0;
                    sec_next   = '0;
                    state_next = C_DIV;
                end
            end
            C_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[31:0] : trial[31:0];
                acc_next  = {acc_reg[tuk_pkg::PROD_W-2:0], trial_ge};
                qbit_next = trial_ge;
                icnt_next = icnt_reg + 1'b1;
                if (icnt_reg == tuk_pkg::ITER_W'(tuk_pkg::PROD_W - 1))
                begin
                    state_next = C_DRAIN;
                end
            end
            C_DRAIN:
            begin
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            dcnt_reg  <= '0;
            icnt_reg  <= '0;
            qvld_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            icnt_reg  <= icnt_next;
            qvld_reg  <= qvld_next;
            done_reg  <= done_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        qbit_reg   <= qbit_next;
        srem_reg   <= srem_next;
        sec_reg    <= sec_next;
    end

    assign done            = done_reg;
    assign result.nsd      = acc_reg;
    assign result.sec_inc  = sec_reg;
    assign result.nsec_rem = srem_reg;

endmodule
